@@ rtl/core/sha256_pkg.sv @@
// Shared types and constants for the SHA-256 stream hasher.
`default_nettype none
package sha256_pkg;
	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       end_of_message;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_LOAD, ST_ROUND, ST_ADD, ST_PAD, ST_EMIT
	} core_state_t;

	localparam logic [7:0] PAD_BYTE = 8'h80;
	localparam int unsigned LenOffset = 56;

	function automatic logic [31:0] init_hash(input logic [2:0] i);
		logic [31:0] r;
		unique case (i)
			3'd0: r = 32'h6a09e667;
			3'd1: r = 32'hbb67ae85;
			3'd2: r = 32'h3c6ef372;
			3'd3: r = 32'ha54ff53a;
			3'd4: r = 32'h510e527f;
			3'd5: r = 32'h9b05688c;
			3'd6: r = 32'h1f83d9ab;
			default: r = 32'h5be0cd19;
		endcase
		return r;
	endfunction

	localparam logic [31:0] K_TAB [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction
endpackage
`default_nettype wire

@@ rtl/core/sha256_front.sv @@
// Input side: accepts items, drops empty ones and queues the rest.
`default_nettype none
module sha256_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire sha256_pkg::cmd_t   in_cmd,
	output logic                    q_valid,
	input  wire logic               q_ready,
	output sha256_pkg::cmd_t        q_cmd
);
	import sha256_pkg::*;

	cmd_t       mem_q [4];
	logic [1:0] wr_q, rd_q;
	logic [2:0] cnt_q;
	logic       push, pop;

	assign in_ready = (cnt_q != 3'd4);
	// Items that carry neither a byte nor an end mark change nothing.
	assign push = in_valid && in_ready && (in_cmd.has_byte || in_cmd.end_of_message);
	assign q_valid = (cnt_q != 3'd0);
	assign pop = q_valid && q_ready;
	assign q_cmd = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= in_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= wr_q + 2'd1;
			if (pop) rd_q <= rd_q + 2'd1;
			cnt_q <= cnt_q + {2'd0, push} - {2'd0, pop};
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n) cnt_q <= 3'd4)
		else $error("queue count overflow");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd0 |-> !pop) else $error("pop from empty queue");
	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q == 3'd4 |-> !in_ready) else $error("ready while full");
endmodule
`default_nettype wire

@@ rtl/core/sha256_back.sv @@
// Back end: block buffer, padding and the 64-round compression engine.
`default_nettype none
module sha256_back (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               q_valid,
	output logic                    q_ready,
	input  wire sha256_pkg::cmd_t   q_cmd,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output logic [31:0]             out_word,
	output logic [2:0]              out_index,
	output logic                    out_last
);
	import sha256_pkg::*;

	core_state_t state_q, state_d;
	logic [31:0] buf_q [16];
	logic [5:0]  fill_q;
	logic [60:0] nbytes_q;
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [6:0]  cnt_q;
	logic        fin_q;     // end of message seen; padding pending or in progress
	logic        lenblk_q;  // padding block being built or compressed carries the length
	logic        padblk_q;  // block being compressed was built by padding
	logic        pad_done_q; // the 0x80 byte already sits in an earlier block
	logic [2:0]  oidx_q;

	logic [31:0] t1, t2, wn, wt, s0, s1;
	logic [31:0] e, a;
	logic [5:0]  pb;
	logic [7:0]  pad_byte;
	logic [63:0] bits;

	assign e = v_q[4];
	assign a = v_q[0];
	assign wt = w_q[0];
	assign s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
	assign s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
	assign wn = s1 + w_q[9] + s0 + w_q[0];
	assign t1 = v_q[7] + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25))
		+ ((e & v_q[5]) ^ (~e & v_q[6])) + K_TAB[cnt_q[5:0]] + wt;
	assign t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22))
		+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
	assign bits = {nbytes_q, 3'b000};
	assign pb = cnt_q[5:0];

	// Byte written at position pb during padding.
	always_comb begin
		pad_byte = 8'h00;
		if (lenblk_q && {26'd0, pb} >= LenOffset)
			pad_byte = bits[8'd63 - {pb[2:0], 3'b000} -: 8];
		else if (pb == fill_q && !pad_done_q)
			pad_byte = PAD_BYTE;
		else if (pb < fill_q)
			pad_byte = buf_q[pb[5:2]][{~pb[1:0], 3'b111} -: 8];
	end

	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid) begin
					if (q_cmd.has_byte && fill_q == 6'd63) state_d = ST_LOAD;
					else if (q_cmd.end_of_message) state_d = ST_PAD;
				end
			end
			ST_PAD: if (cnt_q == 7'd63) state_d = ST_LOAD;
			ST_LOAD: if (cnt_q == 7'd15) state_d = ST_ROUND;
			ST_ROUND: if (cnt_q == 7'd63) state_d = ST_ADD;
			ST_ADD: begin
				if (!fin_q) state_d = ST_IDLE;
				else if (padblk_q && lenblk_q) state_d = ST_EMIT;
				else state_d = ST_PAD;
			end
			ST_EMIT: if (out_ready && oidx_q == 3'd7) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	assign out_valid = (state_q == ST_EMIT);
	assign out_word = h_q[oidx_q];
	assign out_index = oidx_q;
	assign out_last = (oidx_q == 3'd7);

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && q_valid && q_cmd.has_byte)
			buf_q[fill_q[5:2]][{~fill_q[1:0], 3'b111} -: 8] <= q_cmd.data_byte;
		if (state_q == ST_PAD) buf_q[pb[5:2]][{~pb[1:0], 3'b111} -: 8] <= pad_byte;
		if (state_q == ST_LOAD) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= buf_q[cnt_q[3:0]];
			if (cnt_q == 7'd0) for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
		end
		if (state_q == ST_ROUND) begin
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			fill_q <= '0;
			nbytes_q <= '0;
			cnt_q <= '0;
			fin_q <= 1'b0;
			lenblk_q <= 1'b0;
			padblk_q <= 1'b0;
			pad_done_q <= 1'b0;
			oidx_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_IDLE: begin
					cnt_q <= '0;
					if (q_valid) begin
						fin_q <= q_cmd.end_of_message;
						padblk_q <= 1'b0;
						pad_done_q <= 1'b0;
						if (q_cmd.has_byte) begin
							fill_q <= fill_q + 6'd1;
							nbytes_q <= nbytes_q + 61'd1;
						end
						// Length fits after the pad byte when fewer than 56 bytes are held.
						if (q_cmd.has_byte && fill_q == 6'd63) lenblk_q <= 1'b1;
						else lenblk_q <= ((q_cmd.has_byte ? fill_q + 6'd1 : fill_q) < 6'd56);
					end
				end
				ST_PAD: begin
					padblk_q <= 1'b1;
					cnt_q <= (cnt_q == 7'd63) ? 7'd0 : cnt_q + 7'd1;
				end
				ST_LOAD: cnt_q <= (cnt_q == 7'd15) ? 7'd0 : cnt_q + 7'd1;
				ST_ROUND: cnt_q <= cnt_q + 7'd1;
				ST_ADD: begin
					cnt_q <= '0;
					for (int i = 0; i < 8; i++) h_q[i] <= h_q[i] + v_q[i];
					if (fin_q && padblk_q && !lenblk_q) begin
						// Second padding block: pad byte already placed, only zeros and length.
						lenblk_q <= 1'b1;
						pad_done_q <= 1'b1;
						fill_q <= '0;
					end
				end
				ST_EMIT: begin
					if (out_ready) begin
						oidx_q <= oidx_q + 3'd1;
						if (oidx_q == 3'd7) begin
							for (int i = 0; i < 8; i++) h_q[i] <= init_hash(3'(i));
							fill_q <= '0;
							nbytes_q <= '0;
							fin_q <= 1'b0;
							lenblk_q <= 1'b0;
							padblk_q <= 1'b0;
							pad_done_q <= 1'b0;
						end
					end
				end
				default: ;
			endcase
		end
	end

	a_emit_order: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && oidx_q != 3'd7 |=> out_valid)
		else $error("digest cut short");
	a_idx_start: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> oidx_q == 3'd0) else $error("digest starts mid-word");
	a_no_take: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != ST_IDLE |-> !q_ready) else $error("item taken while busy");
endmodule
`default_nettype wire

@@ rtl/core/sha256_stream_hasher.sv @@
// Top level of the SHA-256 stream hasher: queue front end and compression back end.
// A byte item is stored in the block buffer; a block's 64th byte starts its compression.
// End of message pads and compresses one or two blocks, then emits eight digest items
// at one per cycle while m_tready is high.
// A four-entry queue decouples input from the compression engine.
// Reset (arst_n low, asynchronous) loads the initial hash and clears all counts.
`default_nettype none
module sha256_stream_hasher (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,   // data_byte
	input  wire logic [1:0]  s_tuser,   // has_byte, end_of_message
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // digest_word, word_index, 5 zero bits
	output logic             m_tlast    // last_word
);
	import sha256_pkg::*;

	cmd_t       in_cmd, q_cmd;
	logic       q_valid, q_ready;
	logic [31:0] word;
	logic [2:0]  idx;

	assign in_cmd = '{data_byte: s_tdata, has_byte: s_tuser[0], end_of_message: s_tuser[1]};

	sha256_front u_front (
		.clk, .arst_n, .in_valid(s_tvalid), .in_ready(s_tready), .in_cmd,
		.q_valid, .q_ready, .q_cmd
	);

	sha256_back u_back (
		.clk, .arst_n, .q_valid, .q_ready, .q_cmd,
		.out_valid(m_tvalid), .out_ready(m_tready), .out_word(word),
		.out_index(idx), .out_last(m_tlast)
	);

	assign m_tdata = {5'd0, idx, word};
endmodule
`default_nettype wire

@@ bench/testbench.sv @@
// Self-checking testbench for the SHA-256 stream hasher.
`timescale 1ns / 100ps
`default_nettype none
module testbench;
	import sha256_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 2000000;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = 8'h00;
	logic [1:0]  s_tuser = 2'b00;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic        m_tlast;

	typedef struct {
		logic [31:0] word;
		logic [2:0]  idx;
		logic        last;
	} digest_item_t;

	typedef struct {
		logic [7:0]  data_byte;
		logic        has_byte;
		logic        end_of_message;
		logic        typed;
		logic [31:0] word0;
	} stim_row_t;

	// Predictor state.
	logic [31:0] hash_state [8];
	logic [7:0]  pending_block [64];
	int unsigned pending_fill;
	logic [60:0] msg_len;

	digest_item_t digest_queue [$];
	logic [31:0]  typed_word0 [$];
	bit           typed_valid [$];
	int unsigned  error_count = 0;
	int unsigned  digests_seen = 0;
	int unsigned  cycle_count = 0;
	bit           stall_pattern_on = 1'b1;

	sha256_stream_hasher i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [31:0] ror32(logic [31:0] x, int unsigned n);
		return (x >> n) | (x << (32 - n));
	endfunction

	task automatic sha_compress(input logic [7:0] blk [64]);
		logic [31:0] w [64];
		logic [31:0] v [8];
		logic [31:0] s0, s1, t1, t2, ch, mj;
		for (int t = 0; t < 16; t++)
			w[t] = {blk[4*t], blk[4*t+1], blk[4*t+2], blk[4*t+3]};
		for (int t = 16; t < 64; t++) begin
			s0 = ror32(w[t-15], 7) ^ ror32(w[t-15], 18) ^ (w[t-15] >> 3);
			s1 = ror32(w[t-2], 17) ^ ror32(w[t-2], 19) ^ (w[t-2] >> 10);
			w[t] = s1 + w[t-7] + s0 + w[t-16];
		end
		v = hash_state;
		for (int t = 0; t < 64; t++) begin
			ch = (v[4] & v[5]) ^ (~v[4] & v[6]);
			mj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
			t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25)) + ch
				+ K_TAB[t] + w[t];
			t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22)) + mj;
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int k = 0; k < 8; k++)
			hash_state[k] += v[k];
	endtask

	task automatic clear_hash_state();
		hash_state = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		foreach (pending_block[i])
			pending_block[i] = 8'h00;
		pending_fill = 0;
		msg_len = '0;
	endtask

	// Absorbs one accepted item and queues the digest words it finishes.
	task automatic hash_absorb(logic [7:0] b, logic hb, logic eom);
		logic [7:0]  blk [64];
		logic [63:0] bits;
		int unsigned pos;
		if (hb) begin
			pending_block[pending_fill] = b;
			pending_fill++;
			msg_len++;
			if (pending_fill == 64) begin
				sha_compress(pending_block);
				pending_fill = 0;
			end
		end
		if (!eom)
			return;
		blk = pending_block;
		pos = pending_fill;
		blk[pos++] = PAD_BYTE;
		if (pos > LenOffset) begin
			while (pos < 64)
				blk[pos++] = 8'h00;
			sha_compress(blk);
			pos = 0;
		end
		while (pos < LenOffset)
			blk[pos++] = 8'h00;
		bits = {msg_len, 3'b000};
		for (int k = 0; k < 8; k++)
			blk[LenOffset + k] = bits[63 - 8*k -: 8];
		sha_compress(blk);
		for (int k = 0; k < 8; k++)
			digest_queue.push_back('{hash_state[k], 3'(k), k == 7});
		clear_hash_state();
	endtask

	task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
		$display("mismatch at cycle %0d: %s got %h expected %h", cycle_count, what, got, want);
		error_count++;
	endtask

	// Drives one item at the falling edge and holds it until accepted.
	task automatic send_item(logic [7:0] b, logic hb, logic eom);
		s_tdata  <= b;
		s_tuser  <= {eom, hb};
		s_tvalid <= 1'b1;
		do @(posedge clk); while (!s_tready);
		hash_absorb(b, hb, eom);
		@(negedge clk);
	endtask

	task automatic pause_sender(int unsigned n);
		s_tvalid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (digest_queue.size() != 0)
			@(negedge clk);
	endtask

	// Result checker.
	always @(posedge clk) begin
		digest_item_t want;
		cycle_count++;
		if (arst_n && m_tvalid && m_tready) begin
			if (digest_queue.size() == 0) begin
				report_mismatch("unexpected digest item", m_tdata[31:0], 32'h0);
			end else begin
				want = digest_queue.pop_front();
				if (m_tdata[31:0] !== want.word)
					report_mismatch("digest_word", m_tdata[31:0], want.word);
				if (m_tdata[34:32] !== want.idx)
					report_mismatch("word_index", 32'(m_tdata[34:32]), 32'(want.idx));
				if (m_tdata[39:35] !== 5'b0)
					report_mismatch("tdata padding", 32'(m_tdata[39:35]), 32'h0);
				if (m_tlast !== want.last)
					report_mismatch("last_word", 32'(m_tlast), 32'(want.last));
				// Directed messages come first, one entry per finished message.
				if (want.idx == 3'd0 && typed_word0.size() != 0) begin
					if (typed_valid[0] && m_tdata[31:0] !== typed_word0[0])
						report_mismatch("known digest H0", m_tdata[31:0], typed_word0[0]);
					void'(typed_word0.pop_front());
					void'(typed_valid.pop_front());
				end
				if (want.last)
					digests_seen++;
			end
		end
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycle_count);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Receiver stalls at random, with stretches of full readiness.
	always @(negedge clk) begin
		if (!arst_n)
			m_tready <= 1'b0;
		else if (stall_pattern_on)
			m_tready <= ($urandom_range(0, 3) != 0) || (cycle_count[7:5] == 3'd2);
		else
			m_tready <= 1'b1;
	end

	initial begin
		stim_row_t rows [$];
		int unsigned boundary_sizes [5] = '{55, 56, 63, 64, 119};
		int unsigned items_sent;
		int unsigned burst;
		int unsigned msg_size;
		clear_hash_state();
		// Directed rows: H0 of the empty digest and of "abc" are well known.
		rows.push_back('{8'h00, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
		rows.push_back('{8'h61, 1'b1, 1'b0, 1'b0, 32'h0});
		rows.push_back('{8'h5a, 1'b0, 1'b0, 1'b0, 32'h0});
		rows.push_back('{8'h62, 1'b1, 1'b0, 1'b0, 32'h0});
		rows.push_back('{8'h63, 1'b1, 1'b1, 1'b1, 32'hba7816bf});
		rows.push_back('{8'h00, 1'b1, 1'b1, 1'b0, 32'h0});
		rows.push_back('{8'hff, 1'b1, 1'b1, 1'b0, 32'h0});
		rows.push_back('{8'hff, 1'b0, 1'b1, 1'b1, 32'he3b0c442});
		rows.push_back('{8'haa, 1'b1, 1'b0, 1'b0, 32'h0});
		rows.push_back('{8'h55, 1'b1, 1'b0, 1'b0, 32'h0});
		rows.push_back('{8'h00, 1'b0, 1'b1, 1'b0, 32'h0});

		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		foreach (rows[i]) begin
			if (rows[i].end_of_message) begin
				typed_word0.push_back(rows[i].word0);
				typed_valid.push_back(rows[i].typed);
			end
			send_item(rows[i].data_byte, rows[i].has_byte, rows[i].end_of_message);
		end
		wait_drained();

		// Padding boundaries: 55, 56, 63, 64 and 119 bytes, two (56, 64) with a final-item byte.
		foreach (boundary_sizes[j]) begin
			msg_size = boundary_sizes[j];
			for (int k = 0; k < msg_size - 1; k++)
				send_item(8'($urandom), 1'b1, 1'b0);
			send_item(8'($urandom), 1'b1, j[0]);
			if (!j[0])
				send_item(8'h00, 1'b0, 1'b1);
		end
		wait_drained();
		repeat (20) @(negedge clk);

		// Random messages sent in bursts, mostly short, some across blocks.
		items_sent = 0;
		while (items_sent < 130) begin
			stall_pattern_on = !(digests_seen >= 13 && digests_seen < 16);
			msg_size = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 140)
				: $urandom_range(0, 20);
			burst = $urandom_range(1, 12);
			for (int k = 0; k < msg_size; k++) begin
				if ($urandom_range(0, 15) == 0)
					send_item(8'($urandom), 1'b0, 1'b0);
				send_item(8'($urandom), 1'b1, 1'b0);
				items_sent++;
				if (--burst == 0) begin
					pause_sender($urandom_range(1, 6));
					burst = $urandom_range(1, 12);
				end
			end
			if ($urandom_range(0, 1))
				send_item(8'($urandom), 1'b1, 1'b1);
			else
				send_item(8'($urandom), 1'b0, 1'b1);
			items_sent++;
			if ($urandom_range(0, 9) == 0)
				wait_drained();
		end

		wait_drained();
		repeat (400) @(negedge clk);
		$display("Hashed %0d messages, including empty ones and every padding boundary,",
			digests_seen);
		$display("with random sender gaps and receiver stalls.");
		if (error_count == 0 && digest_queue.size() == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end
endmodule
`default_nettype wire
